// ===== rtl/clnwq_pkg.sv =====
// shared types, defaults and helpers for the character lcd nibble write queue
// used by the controller, datapath and top level; no dependencies
package clnwq_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int SLOT_BYTES_DEF = 32;

    localparam logic [6:0] ROW1_BASE = 7'h40;
    localparam logic [6:0] ROW2_BASE = 7'h14;
    localparam logic [6:0] ROW3_BASE = 7'h54;
    localparam logic [6:0] ROW0_BASE = 7'h00;
    localparam logic [7:0] SET_ADDR_CMD = 8'h80;

    typedef struct packed {
        logic       operation;
        logic [5:0] column;
        logic [2:0] row;
        logic [7:0] char_code;
        logic       first_char;
        logic       last_char;
        logic       empty_text;
    } in_item_t;

    typedef struct packed {
        logic [3:0] nibble_out;
        logic       register_select;
        logic       strobe_res;
        logic       accepted;
        logic       overflow;
        logic       busy_res;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_WR2  = 3'b100
    } state_t;

    typedef struct packed {
        logic idle;
        logic capture;
        logic exec;
        logic second;
        logic commit;
    } ctl_t;

    typedef struct packed {
        logic two_write;
        logic out_free;
    } stat_t;

    function automatic logic [6:0] row_base(input logic [2:0] row);
        logic [6:0] base;
        case (row)
            3'd1:    base = ROW1_BASE;
            3'd2:    base = ROW2_BASE;
            3'd3:    base = ROW3_BASE;
            default: base = ROW0_BASE;
        endcase
        return base;
    endfunction

endpackage

// ===== rtl/clnwq_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module clnwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/clnwq_ctrl.sv =====
// controller state machine: item acceptance, write sequencing, result hand-off
// depends on clnwq_pkg
module clnwq_ctrl
    import clnwq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.two_write)
                begin
                    state_next = ST_WR2;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WR2:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.idle    = (state_reg == ST_IDLE);
        ctl.capture = ctl.idle && req_valid;
        ctl.exec    = (state_reg == ST_EXEC);
        ctl.second  = (state_reg == ST_WR2);
        ctl.commit  = ((ctl.exec && !stat.two_write) || ctl.second) && stat.out_free;
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

// ===== rtl/clnwq_datapath.sv =====
// datapath: ring pointers, byte store and slot lengths, result register
// depends on clnwq_pkg and clnwq_ram
module clnwq_datapath
    import clnwq_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  req,
    input  ctl_t      ctl,
    output stat_t     stat,
    output logic      rsp_valid,
    output out_item_t rsp,
    input  logic      rsp_stall
);

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int PW    = $clog2(SLOT_BYTES + 1);
    localparam int DEPTH = SLOT_COUNT * SLOT_BYTES;
    localparam int AW    = $clog2(DEPTH);

    in_item_t  item_reg;
    out_item_t out_reg;
    out_item_t res;
    logic      out_valid_reg;

    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic          phase_reg, phase_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic          rej_reg, rej_next;
    logic          send_reg, send_next;

    logic [SW-1:0] head_inc, tail_inc;
    logic          full;
    logic [6:0]    addr7;
    logic [7:0]    cmd_byte;
    logic [7:0]    byte_rd;
    logic [PW-1:0] len_rd;
    logic [PW-1:0] rp_inc;
    logic          wr_en;
    logic [PW-1:0] wr_pos;
    logic [7:0]    wr_data;
    logic          len_we;
    logic [PW-1:0] commit_len;
    logic [AW-1:0] wr_addr, rd_addr;

    assign head_inc = (head_reg == SW'(SLOT_COUNT - 1)) ? '0 : head_reg + SW'(1);
    assign tail_inc = (tail_reg == SW'(SLOT_COUNT - 1)) ? '0 : tail_reg + SW'(1);
    assign full     = (head_inc == tail_reg);
    assign addr7    = 7'(item_reg.column) + row_base(item_reg.row);
    assign cmd_byte = SET_ADDR_CMD | {1'b0, addr7};

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        rp_next    = rp_reg;
        phase_next = phase_reg;
        wp_next    = wp_reg;
        rej_next   = rej_reg;
        send_next  = send_reg;
        res        = '0;
        rp_inc     = rp_reg;
        wr_en      = 1'b0;
        wr_pos     = '0;
        wr_data    = item_reg.char_code;
        len_we     = 1'b0;
        commit_len = '0;
        if (!item_reg.operation)
        begin
            if (send_reg)
            begin
                if (head_reg == tail_reg)
                begin
                    send_next = 1'b0;
                end
                else
                begin
                    res.nibble_out      = phase_reg ? byte_rd[3:0] : byte_rd[7:4];
                    res.register_select = (rp_reg != '0);
                    res.strobe_res      = 1'b1;
                    phase_next          = !phase_reg;
                    rp_inc              = phase_reg ? rp_reg + PW'(1) : rp_reg;
                    rp_next             = rp_inc;
                    if (rp_inc >= len_rd)
                    begin
                        tail_next  = tail_inc;
                        rp_next    = '0;
                        phase_next = 1'b0;
                    end
                end
            end
        end
        else if (item_reg.first_char)
        begin
            if (full)
            begin
                wp_next      = '0;
                rej_next     = !item_reg.last_char;
                res.overflow = 1'b1;
            end
            else
            begin
                rej_next     = 1'b0;
                res.accepted = 1'b1;
                wr_en        = 1'b1;
                wr_data      = cmd_byte;
                wp_next      = item_reg.empty_text ? PW'(1) : PW'(2);
                if (item_reg.last_char)
                begin
                    len_we     = 1'b1;
                    commit_len = wp_next;
                    head_next  = head_inc;
                    send_next  = 1'b1;
                    wp_next    = '0;
                end
            end
        end
        else if (rej_reg)
        begin
            res.overflow = 1'b1;
            if (item_reg.last_char)
            begin
                rej_next = 1'b0;
            end
        end
        else if (wp_reg == '0)
        begin
            res.overflow = 1'b1;
        end
        else
        begin
            if (wp_reg < PW'(SLOT_BYTES))
            begin
                wr_en        = 1'b1;
                wr_pos       = wp_reg;
                wp_next      = wp_reg + PW'(1);
                res.accepted = 1'b1;
            end
            else
            begin
                res.overflow = 1'b1;
            end
            if (item_reg.last_char)
            begin
                len_we     = 1'b1;
                commit_len = wp_next;
                head_next  = head_inc;
                send_next  = 1'b1;
                wp_next    = '0;
            end
        end
        // second write of a first item puts the character after the command
        if (ctl.second)
        begin
            wr_pos  = PW'(1);
            wr_data = item_reg.char_code;
        end
        res.busy_res = (head_next != tail_next);
    end

    assign stat.two_write = item_reg.operation && item_reg.first_char && !full
                            && !item_reg.empty_text;
    assign stat.out_free  = !out_valid_reg || !rsp_stall;

    assign wr_addr = AW'(head_reg) * AW'(SLOT_BYTES) + AW'(wr_pos);
    assign rd_addr = AW'(tail_reg) * AW'(SLOT_BYTES) + AW'(rp_reg);

    clnwq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_byte_ram (
        .clk   (clk),
        .we    ((ctl.exec && wr_en) || ctl.second),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (ctl.idle),
        .raddr (rd_addr),
        .rdata (byte_rd)
    );

    clnwq_ram #(
        .WIDTH (PW),
        .DEPTH (SLOT_COUNT)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we && ctl.commit),
        .waddr (head_reg),
        .wdata (commit_len),
        .re    (ctl.idle),
        .raddr (tail_reg),
        .rdata (len_rd)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            item_reg <= req;
        end
        if (ctl.commit)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            rp_reg        <= '0;
            phase_reg     <= 1'b0;
            wp_reg        <= '0;
            rej_reg       <= 1'b0;
            send_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                rp_reg    <= rp_next;
                phase_reg <= phase_next;
                wp_reg    <= wp_next;
                rej_reg   <= rej_next;
                send_reg  <= send_next;
            end
            if (ctl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef ASSERT_OFF
    a_rp_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg < PW'(SLOT_BYTES))
        else $error("read position beyond slot");
    a_wp_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= PW'(SLOT_BYTES))
        else $error("write position beyond slot");
    a_rej_closed: assert property (@(posedge clk) disable iff (!rst_n)
        rej_reg |-> (wp_reg == '0))
        else $error("rejected item with open slot");
    a_acc_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.accepted && rsp.overflow))
        else $error("item both stored and dropped");
    a_strobe_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.strobe_res) |-> (!rsp.accepted && !rsp.overflow))
        else $error("strobe on a text item");
`endif

endmodule

// ===== rtl/char_lcd_nibble_write_queue.sv =====
// top level of the character lcd nibble write queue
// depends on clnwq_pkg, clnwq_ctrl and clnwq_datapath
//
// req carries one item: a timer tick (operation 0) or a text character
// (operation 1) with column, row and first/last/empty marks. text items fill
// a ring of SLOT_COUNT slots of SLOT_BYTES bytes; the first character writes
// the set-address command, the last commits the slot. each tick sends one
// nibble of the oldest committed slot, high nibble first.
// rsp gives one result per item: nibble, register select, strobe,
// accepted, overflow and busy.
// rsp_valid rises once the item commits, from ST_EXEC, or from ST_WR2 for a first
// character with text (two byte store writes on the single write port).
// one item is taken at a time: req_stall stays high until it commits;
// the byte store read for a tick is issued while idle and is registered.
// reset clears pointers, flags and the result valid; stores need no clear.
// while rsp is stalled the next item is still taken and worked on; its
// result waits inside until the result register frees, req_stall stays high.
module char_lcd_nibble_write_queue
    import clnwq_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_item_t  req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_item_t rsp
);

    ctl_t  ctl;
    stat_t stat;

    clnwq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    clnwq_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .rsp_stall (rsp_stall)
    );

endmodule
